// ===== rtl/firi_pkg.sv =====
// ----------------------------------------------------------------------------
// firi_pkg : shared types and constants of the stereo FIR interpolator
// Field widths, mode and request codes, fixed-point constants and the
// sequencer state type.
// ----------------------------------------------------------------------------
package firi_pkg;

   // Field widths
   localparam int SAMPLE_W     = 24;
   localparam int COEF_W       = 18;
   localparam int COEF_INDEX_W = 6;
   localparam int PHASE_W      = 2;
   localparam int MODE_W       = 2;

   // Full-precision product of a Q1.23 sample and a Q1.17 tap
   localparam int PROD_W = SAMPLE_W + COEF_W;

   // Rounding back to Q1.23: add half an LSB, then drop 17 bits
   localparam int ROUND_SHIFT = 17;
   localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

   // Saturation limits of a 24-bit signed sample
   localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
   localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));

   // Oversampling mode register codes (the spare code behaves as pass-through)
   localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_X2   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_X4   = 2'd2;

   // Request kinds
   localparam logic REQ_COEF   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // Coefficient table select
   localparam logic TABLE_X2 = 1'b0;
   localparam logic TABLE_X4 = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS,
      ST_RUN,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/firi_if.sv =====
// ----------------------------------------------------------------------------
// firi_if : valid/ready channels of the stereo FIR interpolator
// Request channel (coefficient writes and stereo samples) and result channel.
// ----------------------------------------------------------------------------
interface firi_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  req_type;
   logic                                  coef_table;
   logic [firi_pkg::COEF_INDEX_W-1:0]     coef_index;
   logic signed [firi_pkg::COEF_W-1:0]    coef_value;
   logic signed [firi_pkg::SAMPLE_W-1:0]  sample_left;
   logic signed [firi_pkg::SAMPLE_W-1:0]  sample_right;

   modport source (
      output valid, req_type, coef_table, coef_index, coef_value,
             sample_left, sample_right,
      input  ready
   );
   modport sink (
      input  valid, req_type, coef_table, coef_index, coef_value,
             sample_left, sample_right,
      output ready
   );
endinterface

interface firi_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [firi_pkg::SAMPLE_W-1:0]  out_left;
   logic signed [firi_pkg::SAMPLE_W-1:0]  out_right;
   logic [firi_pkg::PHASE_W-1:0]          phase_index;
   logic                                  last_of_run;
   logic                                  clipped;

   modport source (
      output valid, out_left, out_right, phase_index, last_of_run, clipped,
      input  ready
   );
   modport sink (
      input  valid, out_left, out_right, phase_index, last_of_run, clipped,
      output ready
   );
endinterface

// ===== rtl/fir_interpolator_x2_x4.sv =====
// ----------------------------------------------------------------------------
// fir_interpolator_x2_x4 : stereo polyphase FIR interpolator, 1x / 2x / 4x
// Zero-stuffs each stereo sample by the configured factor and, in 2x or 4x
// mode, filters it with the tap table of that mode on one shared multiplier.
// ----------------------------------------------------------------------------
// A coefficient beat produces no result. A sample beat in 1x mode (or the
// spare mode code) is captured and passed straight through the output
// register as a single result. In 2x or 4x mode the block runs F phases;
// each phase sums N tap products per channel, where N is the number of taps
// that phase uses (at most HISTORY_DEPTH). The single 24x18 multiplier
// handles left then right for every tap. The block takes no request beat
// while a run is in progress; a finished result waits in the output
// register, and the next sample is accepted meanwhile. Tap tables are
// undefined until written.
// ----------------------------------------------------------------------------
module fir_interpolator_x2_x4 #(
   parameter int TAPS_2X       = 32,
   parameter int TAPS_4X       = 64,
   parameter int HISTORY_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [firi_pkg::MODE_W-1:0]   csr_wr_data,
   firi_req_if.sink                      req_chan,
   firi_rsp_if.source                    rsp_chan
);
   import firi_pkg::*;

   localparam int TAPS_MAX = (TAPS_2X > TAPS_4X) ? TAPS_2X : TAPS_4X;
   localparam int K_W      = $clog2(TAPS_MAX + 4);
   localparam int CIDX_W   = (K_W > COEF_INDEX_W) ? K_W : COEF_INDEX_W;
   localparam int T2_AW    = $clog2(TAPS_2X);
   localparam int T4_AW    = $clog2(TAPS_4X);
   localparam int HA_W     = $clog2(HISTORY_DEPTH);
   localparam int J_W      = $clog2(HISTORY_DEPTH + 1);
   localparam int ACC_W    = PROD_W + $clog2(HISTORY_DEPTH) + 1;
   localparam int SCL_W    = ACC_W + 2;

   // Round a phase sum to Q1.23 after scaling by the factor; msb is the clip flag
   function automatic logic [SAMPLE_W:0] round_sat(input logic signed [ACC_W-1:0] acc,
                                                   input logic x4);
      logic signed [SCL_W-1:0] scaled;
      logic signed [SCL_W-1:0] rounded;
      logic                    clip;
      logic [SAMPLE_W-1:0]     value;
      scaled  = x4 ? (SCL_W'(acc) <<< 2) : (SCL_W'(acc) <<< 1);
      rounded = (scaled + SCL_W'(ROUND_BIAS)) >>> ROUND_SHIFT;
      clip    = 1'b0;
      value   = rounded[SAMPLE_W-1:0];
      if (rounded > SCL_W'(SAMPLE_MAX)) begin
         clip  = 1'b1;
         value = SAMPLE_W'(SAMPLE_MAX);
      end else if (rounded < SCL_W'(SAMPLE_MIN)) begin
         clip  = 1'b1;
         value = SAMPLE_W'(SAMPLE_MIN);
      end
      return {clip, value};
   endfunction

   // Sequencer state and control
   state_type              state_ff, state_in;
   logic [MODE_W-1:0]      mode_ff;
   logic                   req_accept;
   logic                   sample_beat;
   logic                   coef_beat;
   logic                   filter_mode;
   logic                   is_x4;
   logic                   start_run;
   logic                   load_pass;
   logic                   emit_fire;
   logic                   issue;
   logic                   more_terms;
   logic                   pipe_busy;
   logic                   last_phase;
   logic                   out_free;

   // Phase, tap and history counters
   logic [PHASE_W-1:0]     phase_ff;
   logic [K_W-1:0]         k_ff;
   logic [J_W-1:0]         j_ff;
   logic [K_W-1:0]         ntaps;
   logic [K_W-1:0]         step;

   // History line: circular buffer of {left, right}, newest at head
   logic [2*SAMPLE_W-1:0]  hist_mem [HISTORY_DEPTH];
   logic [HA_W-1:0]        head_ff;
   logic [HA_W-1:0]        head_in;
   logic [J_W-1:0]         fill_ff;
   logic signed [HA_W:0]   hdiff;
   logic [HA_W-1:0]        haddr;

   // Tap tables
   logic signed [COEF_W-1:0] taps2_mem [TAPS_2X];
   logic signed [COEF_W-1:0] taps4_mem [TAPS_4X];
   logic [CIDX_W-1:0]        cidx;

   // MAC pipeline
   logic                     rd_vld_ff;
   logic                     mul_r_ff;
   logic                     prod_vld_ff;
   logic                     prod_ch_ff;
   logic signed [COEF_W-1:0] tap_rd_ff;
   logic [2*SAMPLE_W-1:0]    hist_rd_ff;
   logic                     hist_ok_ff;
   logic signed [SAMPLE_W-1:0] mul_a;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_left_ff;
   logic signed [ACC_W-1:0]  acc_right_ff;
   logic [SAMPLE_W:0]        res_left;
   logic [SAMPLE_W:0]        res_right;

   // Pass-through capture
   logic signed [SAMPLE_W-1:0] pass_l_ff;
   logic signed [SAMPLE_W-1:0] pass_r_ff;

   // Output register
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] out_left_ff;
   logic signed [SAMPLE_W-1:0] out_right_ff;
   logic [PHASE_W-1:0]         out_phase_ff;
   logic                       out_last_ff;
   logic                       out_clip_ff;

   // Decode of the request beat and mode
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept  = req_chan.valid && req_chan.ready;
   assign sample_beat = req_accept && (req_chan.req_type == REQ_SAMPLE);
   assign coef_beat   = req_accept && (req_chan.req_type == REQ_COEF);
   assign is_x4       = (mode_ff == MODE_X4);
   assign filter_mode = (mode_ff == MODE_X2) || is_x4;
   assign ntaps       = is_x4 ? K_W'(TAPS_4X) : K_W'(TAPS_2X);
   assign step        = is_x4 ? K_W'(4) : K_W'(2);
   assign more_terms  = (k_ff < ntaps) && (j_ff < J_W'(HISTORY_DEPTH));
   assign pipe_busy   = rd_vld_ff || mul_r_ff || prod_vld_ff;
   assign last_phase  = is_x4 ? (phase_ff == PHASE_W'(3)) : (phase_ff == PHASE_W'(1));
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign issue       = (state_ff == ST_RUN) && more_terms && !rd_vld_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and sequencer strobes
   always_comb begin
      state_in      = state_ff;
      start_run     = 1'b0;
      load_pass     = 1'b0;
      emit_fire     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_beat) begin
               if (filter_mode) begin
                  start_run = 1'b1;
                  state_in  = ST_RUN;
               end else begin
                  state_in  = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            if (out_free) begin
               load_pass = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (!more_terms && !pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit_fire = 1'b1;
               state_in  = last_phase ? ST_IDLE : ST_RUN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Phase / tap index / history age counters
   always_ff @(posedge clock) begin
      if (start_run) begin
         phase_ff <= '0;
         k_ff     <= '0;
         j_ff     <= '0;
      end else if (emit_fire && !last_phase) begin
         phase_ff <= phase_ff + 1'b1;
         k_ff     <= K_W'(phase_ff + 1'b1);
         j_ff     <= '0;
      end else if (issue) begin
         k_ff     <= k_ff + step;
         j_ff     <= j_ff + 1'b1;
      end
   end

   // History pointer arithmetic: age j lives at head - j (mod depth)
   assign head_in = (head_ff == HA_W'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   always_comb begin
      hdiff = $signed({1'b0, head_ff}) - $signed({1'b0, j_ff[HA_W-1:0]});
      if (hdiff < 0) begin
         haddr = HA_W'(hdiff + (HA_W + 1)'(HISTORY_DEPTH));
      end else begin
         haddr = HA_W'(hdiff);
      end
   end

   // Head pointer and fill count; entries older than the fill count read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else if (sample_beat) begin
         head_ff <= head_in;
         if (fill_ff != J_W'(HISTORY_DEPTH)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   // History memory
   always_ff @(posedge clock) begin
      if (sample_beat) begin
         hist_mem[head_in] <= {req_chan.sample_left, req_chan.sample_right};
      end
      if (issue) begin
         hist_rd_ff <= hist_mem[haddr];
         hist_ok_ff <= (j_ff < fill_ff);
      end
   end

   // Tap tables; out-of-range writes are dropped
   assign cidx = CIDX_W'(req_chan.coef_index);

   always_ff @(posedge clock) begin
      if (coef_beat && (req_chan.coef_table == TABLE_X2) && (cidx < CIDX_W'(TAPS_2X))) begin
         taps2_mem[cidx[T2_AW-1:0]] <= req_chan.coef_value;
      end
      if (coef_beat && (req_chan.coef_table == TABLE_X4) && (cidx < CIDX_W'(TAPS_4X))) begin
         taps4_mem[cidx[T4_AW-1:0]] <= req_chan.coef_value;
      end
      if (issue) begin
         tap_rd_ff <= is_x4 ? taps4_mem[k_ff[T4_AW-1:0]] : taps2_mem[k_ff[T2_AW-1:0]];
      end
   end

   // MAC pipeline control: read, multiply left, multiply right, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         mul_r_ff    <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= issue;
         mul_r_ff    <= rd_vld_ff;
         prod_vld_ff <= rd_vld_ff || mul_r_ff;
      end
   end

   // Shared multiplier: left channel first after a read, then right
   always_comb begin
      if (!hist_ok_ff) begin
         mul_a = '0;
      end else if (mul_r_ff) begin
         mul_a = hist_rd_ff[SAMPLE_W-1:0];
      end else begin
         mul_a = hist_rd_ff[2*SAMPLE_W-1:SAMPLE_W];
      end
   end
   assign prod_in = PROD_W'(mul_a) * PROD_W'(tap_rd_ff);

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      prod_ch_ff <= mul_r_ff;
   end

   // Accumulators, cleared at the start of every phase
   always_ff @(posedge clock) begin
      if (start_run || emit_fire) begin
         acc_left_ff  <= '0;
         acc_right_ff <= '0;
      end else if (prod_vld_ff) begin
         if (prod_ch_ff) begin
            acc_right_ff <= acc_right_ff + ACC_W'(prod_ff);
         end else begin
            acc_left_ff  <= acc_left_ff + ACC_W'(prod_ff);
         end
      end
   end

   assign res_left  = round_sat(acc_left_ff, is_x4);
   assign res_right = round_sat(acc_right_ff, is_x4);

   // Pass-through sample capture
   always_ff @(posedge clock) begin
      if (sample_beat) begin
         pass_l_ff <= req_chan.sample_left;
         pass_r_ff <= req_chan.sample_right;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_pass || emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_pass) begin
         out_left_ff  <= pass_l_ff;
         out_right_ff <= pass_r_ff;
         out_phase_ff <= '0;
         out_last_ff  <= 1'b1;
         out_clip_ff  <= 1'b0;
      end else if (emit_fire) begin
         out_left_ff  <= res_left[SAMPLE_W-1:0];
         out_right_ff <= res_right[SAMPLE_W-1:0];
         out_phase_ff <= phase_ff;
         out_last_ff  <= last_phase;
         out_clip_ff  <= res_left[SAMPLE_W] || res_right[SAMPLE_W];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_left    = out_left_ff;
   assign rsp_chan.out_right   = out_right_ff;
   assign rsp_chan.phase_index = out_phase_ff;
   assign rsp_chan.last_of_run = out_last_ff;
   assign rsp_chan.clipped     = out_clip_ff;

endmodule
